// ===== rtl/dq_pkg.sv =====
// Shared types and constants for the double-ended queue.
// Used by dq_ctrl and double_ended_queue; depends on nothing.
`default_nettype none

package dq_pkg;

  // Ring depth in words. It must be a power of two so that positions wrap by truncation.
  localparam int CAPACITY = 16;
  localparam int ADDR_W   = $clog2(CAPACITY);
  localparam int DATA_W   = 32;
  // Occupancy counts from 0 to CAPACITY inclusive.
  localparam int OCC_W    = $clog2(CAPACITY + 1);

  // Command codes carried on the input beat.
  typedef enum logic [1:0] {
    CMD_PUSH_FRONT = 2'd0,
    CMD_PUSH_BACK  = 2'd1,
    CMD_POP_FRONT  = 2'd2,
    CMD_POP_BACK   = 2'd3
  } cmd_t;

  // Status codes returned with every result beat.
  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  // Request from the pointer logic to the memory and the result stage.
  typedef struct packed {
    logic              wr_en;
    logic              rd_en;
    logic [ADDR_W-1:0] addr;
    logic              pop_ok;
    status_t           status;
    logic [OCC_W-1:0]  occupancy;
  } dq_req_t;

endpackage

`default_nettype wire

// ===== rtl/dq_ram.sv =====
// Single-port synchronous RAM holding the ring entries, with a registered read.
// Generic; depends on no package.
`default_nettype none

module dq_ram #(
  parameter int ADDR_W = 4,
  parameter int DATA_W = 32
) (
  input  wire logic              clk,
  input  wire logic              wr_en,
  input  wire logic              rd_en,
  input  wire logic [ADDR_W-1:0] addr,
  input  wire logic [DATA_W-1:0] wr_data,
  output logic      [DATA_W-1:0] rd_data
);

  logic [DATA_W-1:0] mem [2**ADDR_W];

  // Write port. No reset: entries are undefined until pushed.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[addr] <= wr_data;
    end
  end

  // Registered read; the data holds until the next read.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[addr];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/dq_ctrl.sv =====
// Front position and count registers with the ring address computation.
// Depends on dq_pkg.
`default_nettype none

module dq_ctrl
  import dq_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       fire,
  input  wire logic [1:0] command,
  output dq_req_t         req
);

  logic [ADDR_W-1:0] head;
  logic [ADDR_W-1:0] head_next;
  logic [OCC_W-1:0]  count;
  logic [OCC_W-1:0]  count_next;
  logic [ADDR_W-1:0] count_lo;
  logic              full;
  logic              empty;

  assign count_lo = count[ADDR_W-1:0];
  assign full     = (count == OCC_W'(CAPACITY));
  assign empty    = (count == '0);

  // Decode the command against the current ends of the ring.
  always_comb begin
    head_next     = head;
    count_next    = count;
    req.wr_en     = 1'b0;
    req.rd_en     = 1'b0;
    req.addr      = head;
    req.pop_ok    = 1'b0;
    req.status    = ST_DONE;
    case (cmd_t'(command))
      CMD_PUSH_FRONT: begin
        if (full) begin
          req.status = ST_FULL;
        end else begin
          head_next  = ADDR_W'(head - 1'b1);
          req.addr   = ADDR_W'(head - 1'b1);
          req.wr_en  = 1'b1;
          count_next = OCC_W'(count + 1'b1);
        end
      end
      CMD_PUSH_BACK: begin
        if (full) begin
          req.status = ST_FULL;
        end else begin
          req.addr   = ADDR_W'(head + count_lo);
          req.wr_en  = 1'b1;
          count_next = OCC_W'(count + 1'b1);
        end
      end
      CMD_POP_FRONT: begin
        if (empty) begin
          req.status = ST_EMPTY;
        end else begin
          req.addr   = head;
          req.rd_en  = 1'b1;
          req.pop_ok = 1'b1;
          head_next  = ADDR_W'(head + 1'b1);
          count_next = OCC_W'(count - 1'b1);
        end
      end
      CMD_POP_BACK: begin
        if (empty) begin
          req.status = ST_EMPTY;
        end else begin
          req.addr   = ADDR_W'(head + count_lo - 1'b1);
          req.rd_en  = 1'b1;
          req.pop_ok = 1'b1;
          count_next = OCC_W'(count - 1'b1);
        end
      end
      default: begin
        req.status = ST_DONE;
      end
    endcase
    req.occupancy = count_next;
    // Memory accesses only happen on an accepted beat.
    req.wr_en = req.wr_en & fire;
    req.rd_en = req.rd_en & fire;
  end

  // The front position and count registers update only on an accepted beat.
  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      count <= '0;
    end else if (fire) begin
      head  <= head_next;
      count <= count_next;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/double_ended_queue.sv =====
// Bounded double-ended queue of signed 32-bit words.
//
// Input channel: command (push front, push back, pop front, pop back) and
// value_in, qualified by in_valid and throttled by in_stall. A beat is
// taken at a rising edge with in_valid high and in_stall low.
// Output channel: value_out, status and occupancy, qualified by out_valid
// and throttled by out_stall. Every input beat yields exactly one result.
// A pop returns the removed word; pushes and pops on an empty queue return
// zero. A push on a full queue is dropped with a full status.
//
// Each result passes through the memory read, with the read stage holding
// its fields, and then the output register. Throughput is one command per
// cycle while in_stall is low, set by the single RAM port, which takes either
// the push write or the pop read. Consecutive commands never touch the same
// entry at the same time, so no forwarding is needed.
//
// Reset (synchronous, active high) empties the queue and the pipeline; the
// store contents are left as they are. When the receiver stalls, the output
// register holds, then the read stage fills, and in_stall rises.
// Depends on dq_pkg, dq_ctrl and dq_ram.
`default_nettype none

module double_ended_queue
  import dq_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     in_valid,
  output logic                          in_stall,
  input  wire logic [1:0]               command,
  input  wire logic signed [DATA_W-1:0] value_in,
  output logic                          out_valid,
  input  wire logic                     out_stall,
  output logic signed [DATA_W-1:0]      value_out,
  output logic [1:0]                    status,
  output logic [OCC_W-1:0]              occupancy
);

  dq_req_t           req;
  logic              fire;
  logic              advance;
  logic [DATA_W-1:0] rd_data;

  logic              s1_valid;
  logic              s1_pop_ok;
  status_t           s1_status;
  logic [OCC_W-1:0]  s1_occ;

  // The read stage moves on when the output register is free or draining.
  assign advance  = s1_valid && (!out_valid || !out_stall);
  assign in_stall = s1_valid && !advance;
  assign fire     = in_valid && !in_stall;

  dq_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .fire    (fire),
    .command (command),
    .req     (req)
  );

  dq_ram #(
    .ADDR_W (ADDR_W),
    .DATA_W (DATA_W)
  ) u_ram (
    .clk     (clk),
    .wr_en   (req.wr_en),
    .rd_en   (req.rd_en),
    .addr    (req.addr),
    .wr_data ($unsigned(value_in)),
    .rd_data (rd_data)
  );

  // Read stage: result fields wait here while the memory delivers the word.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (fire) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      s1_pop_ok <= req.pop_ok;
      s1_status <= req.status;
      s1_occ    <= req.occupancy;
    end
  end

  // Output register: the result beat is held while the receiver stalls.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      value_out <= s1_pop_ok ? $signed(rd_data) : '0;
      status    <= s1_status;
      occupancy <= s1_occ;
    end
  end

  // A refused push only happens with the ring full.
  a_full_occ : assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == ST_FULL) |-> (occupancy == OCC_W'(CAPACITY)))
    else $error("full status with ring not full");

  // An empty pop only happens with the ring empty.
  a_empty_occ : assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == ST_EMPTY) |-> (occupancy == '0))
    else $error("empty status with words stored");

  // Failed commands return zero data.
  a_fail_zero : assert property (@(posedge clk) disable iff (rst)
    out_valid && (status != ST_DONE) |-> (value_out == '0))
    else $error("nonzero data on failed command");

  // Occupancy never exceeds the ring depth.
  a_occ_bound : assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (occupancy <= OCC_W'(CAPACITY)))
    else $error("occupancy beyond capacity");

endmodule

`default_nettype wire
